/* src/text_console_char_writer_defines.svh */
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define TCCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition in one cycle implies a condition in the following cycle.
`define TCCW_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* src/tccw_pkg.sv */
// Shared types, constants and helpers of the text console character writer.
package tccw_pkg;

	localparam int ROW_COUNT_DEF    = 25;
	localparam int COLUMN_COUNT_DEF = 80;

	localparam int CHAR_W      = 8;
	localparam int CELL_WORD_W = 16;
	localparam int CELL_ADDR_W = 11;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [CHAR_W-1:0] BLANK_CHAR      = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CODE    = 8'd10;
	localparam logic [CHAR_W-1:0] BACKSPACE_CODE  = 8'd8;
	localparam logic [CHAR_W-1:0] RESET_ATTRIBUTE = 8'h0F;

	localparam logic KIND_PUT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// word index of a register (paddr[2])
	localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RDWAIT,
		ST_SWEEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CHAR_W-1:0] text_attribute;
	} cfg_t;

	typedef struct packed {
		logic [CELL_WORD_W-1:0] cell_word;
		logic [CELL_ADDR_W-1:0] cursor_cell;
		logic                   screen_cleared;
	} res_t;

	function automatic int addr_width(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

/* src/tccw_chan_if.sv */
// Request and result channel interfaces of the text console character writer.
interface tccw_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic [tccw_pkg::CHAR_W-1:0]          char_code;
	logic [tccw_pkg::CELL_ADDR_W-1:0]     cell_address;

	modport source (output valid, output kind, output char_code, output cell_address,
		input ready);
	modport sink (input valid, input kind, input char_code, input cell_address,
		output ready);
endinterface

interface tccw_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [tccw_pkg::CELL_WORD_W-1:0]     cell_word;
	logic [tccw_pkg::CELL_ADDR_W-1:0]     cursor_cell;
	logic                                 screen_cleared;

	modport source (output valid, output cell_word, output cursor_cell,
		output screen_cleared, input ready);
	modport sink (input valid, input cell_word, input cursor_cell,
		input screen_cleared, output ready);
endinterface

/* src/tccw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [tccw_pkg::addr_width(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [tccw_pkg::addr_width(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/tccw_apb_regs.sv */
// APB configuration register file (text attribute).
module tccw_apb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tccw_pkg::PADDR_W-1:0]   paddr,
	input  logic [tccw_pkg::PDATA_W-1:0]   pwdata,
	output logic [tccw_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	output tccw_pkg::cfg_t                 cfg
);

	logic [tccw_pkg::CHAR_W-1:0] attr_q;
	logic                        wr_attr;

	assign pready  = 1'b1;
	assign wr_attr = psel && penable && pwrite && (paddr[2] == tccw_pkg::REG_TEXT_ATTRIBUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tccw_pkg::RESET_ATTRIBUTE;
		end else if (wr_attr) begin
			attr_q <= pwdata[tccw_pkg::CHAR_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == tccw_pkg::REG_TEXT_ATTRIBUTE) begin
			prdata = tccw_pkg::PDATA_W'(attr_q);
		end
	end

	assign cfg.text_attribute = attr_q;

endmodule

/* src/tccw_ctrl.sv */
// Cursor tracking, request sequencing, clearing sweep and result register.
`include "text_console_char_writer_defines.svh"

module tccw_ctrl #(
	parameter int ROW_COUNT    = tccw_pkg::ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = tccw_pkg::COLUMN_COUNT_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  tccw_pkg::cfg_t                                          cfg,
	tccw_req_if.sink                                                req,
	tccw_res_if.source                                              res,
	output logic                                                    mem_we,
	output logic [tccw_pkg::addr_width(ROW_COUNT*COLUMN_COUNT)-1:0] mem_waddr,
	output logic [tccw_pkg::CELL_WORD_W-1:0]                        mem_wdata,
	output logic                                                    mem_re,
	output logic [tccw_pkg::addr_width(ROW_COUNT*COLUMN_COUNT)-1:0] mem_raddr,
	input  logic [tccw_pkg::CELL_WORD_W-1:0]                        mem_rdata
);

	localparam int CELL_TOTAL = ROW_COUNT * COLUMN_COUNT;
	localparam int ADDR_W     = tccw_pkg::addr_width(CELL_TOTAL);
	localparam int CUR_W      = $clog2(CELL_TOTAL + 1);
	localparam int COL_W      = tccw_pkg::addr_width(COLUMN_COUNT);
	localparam int GAP_W      = COL_W + 1;
	localparam int WORD_W     = tccw_pkg::CELL_WORD_W;

	tccw_pkg::state_t      state_q, state_nx;
	logic [CUR_W-1:0]      cursor_q;
	logic [COL_W-1:0]      col_q;
	logic [ADDR_W-1:0]     sweep_cnt_q;
	logic [WORD_W-1:0]     sweep_word_q;
	logic                  sweep_emit_q;
	logic                  out_valid_q;
	tccw_pkg::res_t        res_q;
	tccw_pkg::res_t        out_q;
	logic                  rd_ok_q;

	logic                  accept;
	logic                  is_put;
	logic                  wrap;
	logic                  sweep_last;
	logic                  out_free;
	logic                  load_out;
	logic [WORD_W-1:0]     put_word;
	logic [WORD_W-1:0]     blank_word;
	logic [WORD_W-1:0]     put_data;
	logic [WORD_W-1:0]     put_res_word;
	logic [ADDR_W-1:0]     put_addr;
	logic                  put_we;
	logic [CUR_W-1:0]      nx_cursor;
	logic [COL_W-1:0]      nx_col;
	logic [GAP_W-1:0]      gap;

	assign accept     = req.valid && req.ready;
	assign is_put     = (req.kind == tccw_pkg::KIND_PUT);
	assign put_word   = {cfg.text_attribute, req.char_code};
	assign blank_word = {cfg.text_attribute, tccw_pkg::BLANK_CHAR};
	assign gap        = GAP_W'(COLUMN_COUNT) - {1'b0, col_q};
	assign sweep_last = (sweep_cnt_q == ADDR_W'(CELL_TOTAL - 1));
	assign out_free   = !out_valid_q || res.ready;

	// put datapath: next cursor, column and the cell written
	always_comb begin
		nx_cursor    = cursor_q;
		nx_col       = col_q;
		put_we       = 1'b0;
		put_addr     = ADDR_W'(cursor_q);
		put_data     = put_word;
		put_res_word = '0;
		priority if (req.char_code == tccw_pkg::NEWLINE_CODE) begin
			nx_cursor = cursor_q + CUR_W'(gap);
			nx_col    = '0;
		end else if (req.char_code == tccw_pkg::BACKSPACE_CODE) begin
			if (cursor_q != '0) begin
				nx_cursor    = cursor_q - CUR_W'(1);
				nx_col       = (col_q == '0) ? COL_W'(COLUMN_COUNT - 1) : col_q - COL_W'(1);
				put_we       = 1'b1;
				put_addr     = ADDR_W'(cursor_q - CUR_W'(1));
				put_data     = blank_word;
				put_res_word = blank_word;
			end
		end else begin
			nx_cursor    = cursor_q + CUR_W'(1);
			nx_col       = (col_q == COL_W'(COLUMN_COUNT - 1)) ? '0 : col_q + COL_W'(1);
			put_we       = 1'b1;
			put_res_word = put_word;
		end
		wrap = (nx_cursor >= CUR_W'(CELL_TOTAL));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (!is_put) begin
						state_nx = tccw_pkg::ST_RDWAIT;
					end else if (wrap) begin
						state_nx = tccw_pkg::ST_SWEEP;
					end else begin
						state_nx = tccw_pkg::ST_EMIT;
					end
				end
			end
			tccw_pkg::ST_RDWAIT: begin
				state_nx = tccw_pkg::ST_EMIT;
			end
			tccw_pkg::ST_SWEEP: begin
				if (sweep_last) begin
					state_nx = sweep_emit_q ? tccw_pkg::ST_EMIT : tccw_pkg::ST_IDLE;
				end
			end
			tccw_pkg::ST_EMIT: begin
				if (out_free) begin
					state_nx = tccw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = tccw_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs and memory controls
	always_comb begin
		req.ready = (state_q == tccw_pkg::ST_IDLE);
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = put_addr;
		mem_wdata = put_data;
		mem_raddr = ADDR_W'(req.cell_address);
		load_out  = 1'b0;
		unique case (state_q)
			tccw_pkg::ST_IDLE: begin
				mem_re = accept && !is_put;
				// a wrapping put is blanked by the sweep anyway
				mem_we = accept && is_put && put_we && !wrap;
			end
			tccw_pkg::ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_cnt_q;
				mem_wdata = sweep_word_q;
			end
			tccw_pkg::ST_EMIT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	// control registers; reset starts the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tccw_pkg::ST_SWEEP;
			cursor_q     <= '0;
			col_q        <= '0;
			sweep_cnt_q  <= '0;
			sweep_word_q <= {tccw_pkg::RESET_ATTRIBUTE, tccw_pkg::BLANK_CHAR};
			sweep_emit_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == tccw_pkg::ST_IDLE && accept && is_put) begin
				cursor_q <= wrap ? '0 : nx_cursor;
				col_q    <= wrap ? '0 : nx_col;
				if (wrap) begin
					sweep_cnt_q  <= '0;
					sweep_word_q <= blank_word;
					sweep_emit_q <= 1'b1;
				end
			end
			if (state_q == tccw_pkg::ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + ADDR_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == tccw_pkg::ST_IDLE && accept) begin
			if (is_put) begin
				res_q.cell_word      <= put_res_word;
				res_q.cursor_cell    <= wrap ? '0 : tccw_pkg::CELL_ADDR_W'(nx_cursor);
				res_q.screen_cleared <= wrap;
			end else begin
				rd_ok_q              <= ({1'b0, req.cell_address} < 12'(CELL_TOTAL)) ||
				                        (CELL_TOTAL > 2047);
				res_q.cursor_cell    <= tccw_pkg::CELL_ADDR_W'(cursor_q);
				res_q.screen_cleared <= 1'b0;
			end
		end
		if (state_q == tccw_pkg::ST_RDWAIT) begin
			res_q.cell_word <= rd_ok_q ? mem_rdata : '0;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.cell_word      = out_q.cell_word;
	assign res.cursor_cell    = out_q.cursor_cell;
	assign res.screen_cleared = out_q.screen_cleared;

	`TCCW_ASSERT(a_cursor_in_range, cursor_q < CUR_W'(CELL_TOTAL), "cursor past last cell")
	`TCCW_ASSERT(a_col_in_range, col_q <= COL_W'(COLUMN_COUNT - 1), "column out of range")
	`TCCW_ASSERT(a_sweep_home, (state_q == tccw_pkg::ST_SWEEP) |-> (cursor_q == '0 && col_q == '0), "cursor not home during sweep")
	`TCCW_ASSERT(a_write_owner, mem_we |-> (state_q == tccw_pkg::ST_IDLE || state_q == tccw_pkg::ST_SWEEP), "cell write outside put or sweep")
	`TCCW_ASSERT_NEXT(a_read_lands, state_q == tccw_pkg::ST_RDWAIT, state_q == tccw_pkg::ST_EMIT, "read result not emitted")

endmodule

/* src/text_console_char_writer.sv */
// Top level of the text console character writer.
//
// Use: requests come in on the request channel (valid/ready); each one gives
// exactly one result on the result channel. kind 0 puts char_code at the
// cursor (newline jumps to the next row start, backspace blanks the cell
// before the cursor), kind 1 reads cell cell_address for display refresh.
// Every result carries the cursor cell after the request.
// Sequence: a put is accepted, then its result loaded; a read passes a wait
// state between the two (the cell RAM read is registered). A put that runs past
// the last cell blanks the whole buffer, one cell per cycle on the RAM write
// port, and reports screen_cleared. One request is in flight at a time.
// Reset: the cursor returns to cell 0 and a clearing pass writes a blank
// with attribute 0x0F into all ROW_COUNT*COLUMN_COUNT cells; requests wait
// until it ends, APB writes are taken meanwhile.
// Stall: the result sits in an output register, and the next request is
// accepted while it waits; a finished result that cannot be loaded holds
// the block until the receiver takes the previous one.
// The text attribute register lies at APB address 0.
module text_console_char_writer #(
	parameter int ROW_COUNT    = tccw_pkg::ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = tccw_pkg::COLUMN_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tccw_req_if.sink                       request,
	tccw_res_if.source                     result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tccw_pkg::PADDR_W-1:0]   paddr,
	input  logic [tccw_pkg::PDATA_W-1:0]   pwdata,
	output logic [tccw_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);

	localparam int CELL_TOTAL = ROW_COUNT * COLUMN_COUNT;
	localparam int ADDR_W     = tccw_pkg::addr_width(CELL_TOTAL);

	tccw_pkg::cfg_t                     cfg;
	logic                               mem_we;
	logic [ADDR_W-1:0]                  mem_waddr;
	logic [tccw_pkg::CELL_WORD_W-1:0]   mem_wdata;
	logic                               mem_re;
	logic [ADDR_W-1:0]                  mem_raddr;
	logic [tccw_pkg::CELL_WORD_W-1:0]   mem_rdata;

	// configuration register
	tccw_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// cursor, sequencing, sweep and output register
	tccw_ctrl #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (request),
		.res       (result),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// character cell buffer, attribute above character
	tccw_ram #(
		.WIDTH (tccw_pkg::CELL_WORD_W),
		.DEPTH (CELL_TOTAL)
	) u_cells (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

/* dv/tccw_console_check.sv */
// Result checker for the text console character writer: predicts each result and compares it.
`timescale 1ns / 1ps

module tccw_console_check import tccw_pkg::*; #(
	parameter int ROW_COUNT    = ROW_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	tccw_req_if                req,
	tccw_res_if                res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatch_count,
	output int                 owed_count
);

	localparam int CELL_TOTAL = ROW_COUNT * COLUMN_COUNT;

	logic [CELL_WORD_W-1:0] screen [CELL_TOTAL];
	logic [CELL_ADDR_W-1:0] cursor;
	logic [CHAR_W-1:0]      attribute;
	res_t                   owed_results [$];

	function automatic void blank_screen();
		for (int i = 0; i < CELL_TOTAL; i++) begin
			screen[CELL_ADDR_W'(i)] = {attribute, BLANK_CHAR};
		end
		cursor = '0;
	endfunction

	// Applies one request to the screen copy and returns the result it owes.
	function automatic res_t apply_request(input logic kind, input logic [CHAR_W-1:0] ch,
		input logic [CELL_ADDR_W-1:0] addr);
		res_t r;
		int   pos;
		r = '0;
		if (kind == KIND_READ) begin
			if (int'(addr) < CELL_TOTAL) begin
				r.cell_word = screen[addr];
			end
		end else begin
			pos = int'(cursor);
			if (ch == NEWLINE_CODE) begin
				pos = pos + COLUMN_COUNT - pos % COLUMN_COUNT;
			end else if (ch == BACKSPACE_CODE) begin
				if (pos > 0) begin
					pos--;
					r.cell_word = {attribute, BLANK_CHAR};
					screen[CELL_ADDR_W'(pos)] = r.cell_word;
				end
			end else begin
				r.cell_word = {attribute, ch};
				screen[CELL_ADDR_W'(pos)] = r.cell_word;
				pos++;
			end
			if (pos >= CELL_TOTAL) begin
				// word written before the wrap is still reported
				blank_screen();
				pos = 0;
				r.screen_cleared = 1'b1;
			end
			cursor = CELL_ADDR_W'(pos);
		end
		r.cursor_cell = cursor;
		return r;
	endfunction

	task automatic flag_field(input string name, input logic [CELL_WORD_W-1:0] want,
		input logic [CELL_WORD_W-1:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			attribute = RESET_ATTRIBUTE;
			blank_screen();
			owed_results.delete();
			owed_count = 0;
			mismatch_count = 0;
		end else begin
			// result first: it always belongs to an older request
			if (res.valid && res.ready) begin
				if (owed_results.size() == 0) begin
					mismatch_count++;
					$display("%0t: result expected none, got cell_word %0h cursor_cell %0d",
						$time, res.cell_word, res.cursor_cell);
				end else begin
					want = owed_results.pop_front();
					flag_field("cell_word", want.cell_word, res.cell_word);
					flag_field("cursor_cell", CELL_WORD_W'(want.cursor_cell),
						CELL_WORD_W'(res.cursor_cell));
					flag_field("screen_cleared", CELL_WORD_W'(want.screen_cleared),
						CELL_WORD_W'(res.screen_cleared));
				end
			end
			if (req.valid && req.ready) begin
				owed_results.push_back(apply_request(req.kind, req.char_code, req.cell_address));
			end
			if (psel && penable && pwrite && pready && paddr[2] == REG_TEXT_ATTRIBUTE) begin
				attribute = pwdata[CHAR_W-1:0];
			end
			owed_count = owed_results.size();
		end
	end

endmodule

/* dv/text_console_char_writer_test.sv */
// Testbench top for the text console character writer: stimulus, idling and verdict.
`timescale 1ns / 1ps

module text_console_char_writer_test import tccw_pkg::*;;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatch_count;
	int owed_count;
	int sent;                              // requests accepted so far
	bit steady;                            // when set, neither side idles
	logic [CELL_ADDR_W-1:0] last_cursor;   // cursor from the newest result taken

	tccw_req_if request();
	tccw_res_if result();

	text_console_char_writer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	tccw_console_check predict (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (request),
		.res            (result),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.owed_count     (owed_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop. The slowest legal run (every wrap walking all 2000 cells,
	// full stalls on both sides, the clearing pass after reset) stays well
	// under a tenth of this.
	initial begin
		#10ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Sends one request. Called at a falling edge and returns at one, with
	// valid still high so back-to-back requests need no extra drop.
	task automatic send_request(input logic kind, input logic [CHAR_W-1:0] ch,
		input logic [CELL_ADDR_W-1:0] addr);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			request.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		request.valid        <= 1'b1;
		request.kind         <= kind;
		request.char_code    <= ch;
		request.cell_address <= addr;
		do @(posedge clk); while (!request.ready);
		sent++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every owed result has been taken.
	task automatic settle();
		request.valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Ordinary character that is neither newline nor backspace.
	function automatic logic [CHAR_W-1:0] plain_char();
		logic [CHAR_W-1:0] ch;
		ch = CHAR_W'($urandom_range(0, 255));
		if (ch == NEWLINE_CODE || ch == BACKSPACE_CODE) begin
			ch = ch ^ 8'h40;
		end
		return ch;
	endfunction

	// One request of mixed typing: reads (some out of range), newlines,
	// backspaces and any character code.
	task automatic typing_request();
		int pick;
		logic [CELL_ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		addr = CELL_ADDR_W'($urandom_range(0, 2047));
		if (pick < 15) begin
			// half the reads land on cells written recently
			if ($urandom_range(0, 1) == 0) begin
				addr = CELL_ADDR_W'($urandom_range(0, int'(last_cursor)));
			end
			send_request(KIND_READ, CHAR_W'($urandom_range(0, 255)), addr);
		end else if (pick < 25) begin
			send_request(KIND_PUT, NEWLINE_CODE, addr);
		end else if (pick < 35) begin
			send_request(KIND_PUT, BACKSPACE_CODE, addr);
		end else begin
			send_request(KIND_PUT, CHAR_W'($urandom_range(0, 255)), addr);
		end
	endtask

	// Walks the cursor down to the last row, then fills it so that an
	// ordinary character lands on the last cell and wraps the screen.
	task automatic finish_page();
		int rows;
		settle();
		rows = int'(last_cursor) / COLUMN_COUNT_DEF;
		repeat (ROW_COUNT_DEF - 1 - rows)
			send_request(KIND_PUT, NEWLINE_CODE, CELL_ADDR_W'($urandom_range(0, 2047)));
		repeat (COLUMN_COUNT_DEF + 2)
			send_request(KIND_PUT, plain_char(), CELL_ADDR_W'($urandom_range(0, 2047)));
	endtask

	// Result side: per result draw a stall; a stall holds ready low until the
	// result shows up and then for the drawn number of cycles.
	initial begin
		int stall;
		result.ready = 1'b0;
		last_cursor = '0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result.ready <= 1'b0;
				while (!result.valid) @(negedge clk);
				repeat (stall) @(negedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!(result.valid && result.ready));
			last_cursor = result.cursor_cell;
		end
	end

	initial begin
		logic [CHAR_W-1:0] shades [6];
		int target;
		int burst;

		shades = '{RESET_ATTRIBUTE, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h00};
		shades[5] = CHAR_W'($urandom_range(0, 255));
		sent = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		request.valid = 1'b0;
		request.kind = KIND_PUT;
		request.char_code = '0;
		request.cell_address = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, reset attribute. Requests are held off by the block
		// until its clearing pass ends.
		send_request(KIND_PUT, BACKSPACE_CODE, 11'h7FF);  // backspace at cell 0: no-op
		send_request(KIND_READ, 8'hFF, 11'd0);            // reset blank
		send_request(KIND_READ, 8'h00, 11'd1999);         // last cell
		send_request(KIND_READ, 8'h00, 11'd2000);         // first address past the end
		send_request(KIND_READ, 8'hFF, 11'h7FF);          // top of the address range
		send_request(KIND_PUT, 8'h00, 11'd0);
		send_request(KIND_PUT, 8'hFF, 11'h7FF);
		send_request(KIND_PUT, 8'h41, 11'd1234);          // address ignored on put
		send_request(KIND_READ, NEWLINE_CODE, 11'd1);     // char code ignored on read
		send_request(KIND_PUT, BACKSPACE_CODE, 11'd0);    // blanks cell 2
		send_request(KIND_READ, BACKSPACE_CODE, 11'd2);
		send_request(KIND_PUT, NEWLINE_CODE, 11'd0);
		send_request(KIND_PUT, NEWLINE_CODE, 11'd0);
		send_request(KIND_PUT, BACKSPACE_CODE, 11'd0);    // back across a row start
		send_request(KIND_PUT, 8'h7E, 11'd0);
		send_request(KIND_READ, 8'h00, 11'd159);
		send_request(KIND_READ, 8'h00, 11'd80);

		// Random part: one phase per attribute setting. Writes happen only
		// once the block has handed back every result.
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				settle();
				write_register(PADDR_W'(0), {24'($urandom), shades[phase]});
				if (phase == 3) begin
					// address past the register list: must be ignored
					write_register(PADDR_W'(4), $urandom);
				end
			end
			if (phase % 2 == 1) begin
				finish_page();
			end
			target = sent + 65;
			while (sent < target) begin
				burst = $urandom_range(0, 9);
				steady = ($urandom_range(0, 3) == 0);
				if (burst < 6) begin
					repeat ($urandom_range(1, 20)) begin
						if (sent < target) typing_request();
					end
				end else if (burst < 8) begin
					// newline runs push the cursor off the bottom
					repeat ($urandom_range(1, 6)) begin
						if (sent < target)
							send_request(KIND_PUT, NEWLINE_CODE,
								CELL_ADDR_W'($urandom_range(0, 2047)));
					end
				end else begin
					// a line at least as long as the row
					repeat ($urandom_range(80, 100)) begin
						if (sent < target)
							send_request(KIND_PUT, plain_char(),
								CELL_ADDR_W'($urandom_range(0, 2047)));
					end
				end
			end
			steady = 1'b0;
		end

		settle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/tccw_pkg.sv
src/tccw_chan_if.sv
src/tccw_ram.sv
src/tccw_apb_regs.sv
src/tccw_ctrl.sv
src/text_console_char_writer.sv
dv/tccw_console_check.sv
dv/text_console_char_writer_test.sv
